[src/isl_pkg.sv]
package isl_pkg;

  localparam int TABLE_DEPTH     = 64;
  localparam int VALUE_FRAC_BITS = 16;
  localparam int VALUE_W         = 8 + VALUE_FRAC_BITS;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int WEIGHT_SHIFT    = 16;
  localparam int WEIGHT_W        = WEIGHT_SHIFT + 1;
  localparam int STEP_W          = $clog2(WEIGHT_SHIFT);

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_SHIFT;
  localparam logic [IDX_W-1:0]    LAST_RESET = IDX_W'(44);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   entry_index;
    logic [VALUE_W-1:0] entry_value;
    logic [VALUE_W-1:0] query_z;
  } isl_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    seg_index;
    logic [WEIGHT_W-1:0] weight_low;
    logic [WEIGHT_W-1:0] weight_high;
  } isl_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RDL,
    S_SCAN,
    S_DIV
  } isl_state_t;

endpackage

[src/interp_segment_locator.sv]
// channel   signals                   handshake
// request   start, busy, req          taken when start high and busy low
// result    done, rsp                 valid for the single cycle done is high
// config    cfg_we, cfg_wdata         last_index written when cfg_we high
//
// loads write the table ram in the accept cycle and leave busy low
// a query clamped above entry 0 ends after the entry 0 read, at or below entry last_index after
// the entry last_index read; otherwise it reads and scans, one ram read per cycle, then runs
// the bit-serial divider, which skips its bit steps when the divisor is zero or the weight saturates
// rst clears control and sets last_index to 44; the table is undefined until loaded
// done shows each result once in the cycle busy drops, the receiver cannot stall
module interp_segment_locator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  isl_pkg::isl_req_t         req,
  input  logic                      cfg_we,
  input  logic [isl_pkg::IDX_W-1:0] cfg_wdata,
  output logic                      done,
  output isl_pkg::isl_rsp_t         rsp
);
  import isl_pkg::*;

  isl_state_t         state, state_next;
  logic [IDX_W-1:0]   last_index;
  logic [IDX_W-1:0]   last, last_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [VALUE_W-1:0] z, z_next;
  logic [VALUE_W-1:0] top_val, top_next;
  isl_rsp_t           rsp_next;
  logic               done_next;

  logic [IDX_W-1:0]    ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;
  logic                ram_we;
  logic                div_start;
  logic                div_done;
  logic [VALUE_W-1:0]  div_num;
  logic [VALUE_W-1:0]  div_den;
  logic [WEIGHT_W-1:0] div_q;

  assign busy   = state != S_IDLE;
  assign ram_we = start && !busy && req.op == OP_LOAD;

  isl_table_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.entry_index),
    .wdata (req.entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  isl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_num = (top_val >= z) ? top_val - z : '0;
  assign div_den = (top_val >= ram_rdata) ? top_val - ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      last_index <= LAST_RESET;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        last_index <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    last    <= last_next;
    idx     <= idx_next;
    z       <= z_next;
    top_val <= top_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next = state;
    last_next  = last;
    idx_next   = idx;
    z_next     = z;
    top_next   = top_val;
    rsp_next   = rsp;
    done_next  = 1'b0;
    ram_raddr  = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start && req.op == OP_QUERY) begin
          z_next     = req.query_z;
          last_next  = last_index;
          state_next = S_RD0;
        end
      end
      S_RD0: begin
        top_next = ram_rdata;
        if (z > ram_rdata) begin
          rsp_next   = '{seg_index: '0, weight_low: WEIGHT_ONE, weight_high: '0};
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          ram_raddr  = last;
          state_next = S_RDL;
        end
      end
      S_RDL: begin
        if (z <= ram_rdata) begin
          rsp_next   = '{seg_index: last, weight_low: WEIGHT_ONE, weight_high: '0};
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = '0;
          ram_raddr  = IDX_W'(1);
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // ram_rdata holds entry idx + 1
        if ((idx + IDX_W'(1)) < last && ram_rdata > z) begin
          top_next  = ram_rdata;
          idx_next  = idx + IDX_W'(1);
          ram_raddr = idx + IDX_W'(2);
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          rsp_next   = '{seg_index: idx, weight_low: WEIGHT_ONE - div_q, weight_high: div_q};
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.weight_low + rsp.weight_high) == WEIGHT_ONE)
    else $error("weights do not sum to one");
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.seg_index <= last) else $error("segment beyond last entry");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op == OP_QUERY) |=> busy)
    else $error("query request not taken");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op == OP_LOAD) |=> (!busy && !done))
    else $error("load request left block busy");
`endif

endmodule

[src/isl_table_ram.sv]
module isl_table_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [isl_pkg::IDX_W-1:0] waddr,
  input  logic [isl_pkg::VALUE_W-1:0] wdata,
  input  logic [isl_pkg::IDX_W-1:0] raddr,
  output logic [isl_pkg::VALUE_W-1:0] rdata
);
  import isl_pkg::*;

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/isl_divider.sv]
module isl_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [isl_pkg::VALUE_W-1:0]  num,
  input  logic [isl_pkg::VALUE_W-1:0]  den,
  output logic                         done,
  output logic [isl_pkg::WEIGHT_W-1:0] quotient
);
  import isl_pkg::*;

  logic                    running;
  logic [STEP_W-1:0]       step;
  logic [VALUE_W-1:0]      rem;
  logic [VALUE_W-1:0]      divisor;
  logic [WEIGHT_SHIFT-1:0] qbits;
  logic [VALUE_W:0]        shifted;
  logic                    fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (den == '0) begin
          quotient <= '0;
          done     <= 1'b1;
        end else if (num >= den) begin
          // quotient reaches one or more, saturate
          quotient <= WEIGHT_ONE;
          done     <= 1'b1;
        end else begin
          rem     <= num;
          divisor <= den;
          qbits   <= '0;
          running <= 1'b1;
        end
      end else if (running) begin
        if (fits) begin
          rem <= VALUE_W'(shifted - {1'b0, divisor});
        end else begin
          rem <= VALUE_W'(shifted);
        end
        qbits <= {qbits[WEIGHT_SHIFT-2:0], fits};
        step  <= step + STEP_W'(1);
        if (step == STEP_W'(WEIGHT_SHIFT - 1)) begin
          running  <= 1'b0;
          done     <= 1'b1;
          quotient <= {1'b0, qbits[WEIGHT_SHIFT-2:0], fits};
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_q_range: assert property (@(posedge clk) disable iff (rst)
    done |-> quotient <= WEIGHT_ONE) else $error("quotient above one");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    running |-> !start) else $error("divider restarted while running");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    (running && step == STEP_W'(WEIGHT_SHIFT - 1)) |=> (done && !running))
    else $error("divider did not finish");
`endif

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import isl_pkg::*;

  typedef struct {
    isl_req_t rq;
    bit       typed;
    isl_rsp_t rs;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  isl_req_t         req = '0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;
  logic             done;
  isl_rsp_t         rsp;

  logic [VALUE_W-1:0] bp_shadow [TABLE_DEPTH];
  logic [IDX_W-1:0]   last_shadow = LAST_RESET;
  isl_rsp_t           pending_segments [$];
  dir_row_t           dir_rows [$];

  int burst_left = 0;
  int n_errors = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_settings = 0;

  interp_segment_locator u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // segment search and interpolation weights against the shadow table
  function automatic isl_rsp_t locate_segment(input logic [VALUE_W-1:0] z);
    isl_rsp_t           r;
    int unsigned        k;
    logic [VALUE_W-1:0] top;
    logic [VALUE_W-1:0] bot;
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] den;
    logic [39:0]        frac;
    frac = '0;
    if (z > bp_shadow[0]) begin
      k = 0;
    end else if (z <= bp_shadow[last_shadow]) begin
      k = last_shadow;
    end else begin
      k = 0;
      while (k + 1 < last_shadow && bp_shadow[k + 1] > z) k++;
      top = bp_shadow[k];
      bot = bp_shadow[k + 1];
      num = (top >= z) ? top - z : '0;
      den = (top >= bot) ? top - bot : '0;
      if (den != 0) begin
        frac = (40'(num) << WEIGHT_SHIFT) / den;
        if (frac > WEIGHT_ONE) frac = WEIGHT_ONE;
      end
    end
    r.seg_index   = IDX_W'(k);
    r.weight_high = WEIGHT_W'(frac);
    r.weight_low  = WEIGHT_ONE - r.weight_high;
    return r;
  endfunction

  function automatic void add_row(input logic op, input int idx, input int val, input int z,
                                  input bit typed = 1'b0, input int si = 0,
                                  input int wl = 0, input int wh = 0);
    dir_row_t row;
    row.rq.op             = op;
    row.rq.entry_index    = IDX_W'(idx);
    row.rq.entry_value    = VALUE_W'(val);
    row.rq.query_z        = VALUE_W'(z);
    row.typed             = typed;
    row.rs.seg_index      = IDX_W'(si);
    row.rs.weight_low     = WEIGHT_W'(wl);
    row.rs.weight_high    = WEIGHT_W'(wh);
    dir_rows.push_back(row);
  endfunction

  // bursts of requests with random gaps between them
  task automatic send_request(input isl_req_t r, input bit typed, input isl_rsp_t typed_rsp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    burst_left--;
    if (r.op == OP_LOAD) begin
      bp_shadow[r.entry_index] = r.entry_value;
      n_loads++;
    end else begin
      pending_segments.push_back(typed ? typed_rsp : locate_segment(r.query_z));
      n_queries++;
    end
  endtask

  task automatic write_last_index(input logic [IDX_W-1:0] v);
    start <= 1'b0;
    burst_left = 0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    last_shadow = v;
    n_settings++;
  endtask

  // non-increasing breakpoints from entry 0 through last_index + 1, or through entry 63 when last_index is 63
  task automatic load_descending();
    isl_req_t    r;
    int          upto;
    int unsigned v;
    int unsigned step;
    upto = (last_shadow == TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : last_shadow + 1;
    v = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : $urandom_range(24'h400000, 24'hFFFFFF);
    for (int i = 0; i <= upto; i++) begin
      r.op          = OP_LOAD;
      r.entry_index = IDX_W'(i);
      r.entry_value = VALUE_W'(v);
      r.query_z     = VALUE_W'($urandom());
      send_request(r, 1'b0, '0);
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 2 * v / (upto + 1 - i));
      v = (step > v) ? 0 : v - step;
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_query();
    int          k;
    int unsigned top;
    int unsigned bot;
    k   = $urandom_range(0, last_shadow);
    top = bp_shadow[k];
    bot = (k < TABLE_DEPTH - 1) ? bp_shadow[k + 1] : 0;
    case ($urandom_range(0, 9))
      0: return VALUE_W'($urandom());
      1: return bp_shadow[k];
      2: return bp_shadow[k] + VALUE_W'($urandom_range(0, 4)) - VALUE_W'(2);
      3: return ($urandom_range(0, 1) == 0) ? VALUE_W'(24'hFFFFFF) : bp_shadow[0] + 1'b1;
      4: return ($urandom_range(0, 1) == 0) ? '0 : bp_shadow[last_shadow] - 1'b1;
      default: return (top >= bot) ? VALUE_W'($urandom_range(bot, top)) : VALUE_W'(top);
    endcase
  endfunction

  task automatic run_phase(input int n_items);
    isl_req_t r;
    int       n_base;
    int       pick;
    n_base = n_loads + n_queries;
    load_descending();
    while (n_loads + n_queries - n_base < n_items) begin
      pick          = $urandom_range(0, 99);
      r.entry_index = IDX_W'($urandom());
      r.entry_value = VALUE_W'($urandom());
      r.query_z     = VALUE_W'($urandom());
      if (pick < 3) begin
        load_descending();
      end else if (pick < 10) begin
        r.op = OP_LOAD;
        send_request(r, 1'b0, '0);
      end else begin
        r.op      = OP_QUERY;
        r.query_z = pick_query();
        send_request(r, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    isl_rsp_t want;
    if (!rst && done) begin
      if (pending_segments.size() == 0) begin
        report_mismatch("result with no query outstanding, seg_index", rsp.seg_index, 0);
      end else begin
        want = pending_segments.pop_front();
        n_checked++;
        if (rsp.seg_index !== want.seg_index)
          report_mismatch("seg_index", rsp.seg_index, want.seg_index);
        if (rsp.weight_low !== want.weight_low)
          report_mismatch("weight_low", rsp.weight_low, want.weight_low);
        if (rsp.weight_high !== want.weight_high)
          report_mismatch("weight_high", rsp.weight_high, want.weight_high);
      end
    end
  end

  initial begin
    isl_req_t         r;
    logic [IDX_W-1:0] phase_last [7];

    // table base: entry i = (63 - i) * 4.0 + 0.5
    add_row(OP_QUERY, 0, 0, 'hFFFFFF, 1'b1, 0, 65536, 0);
    add_row(OP_QUERY, 0, 0, 'h000000, 1'b1, 44, 65536, 0);
    add_row(OP_QUERY, 0, 0, 'hFC8000, 1'b1, 0, 65536, 0);
    add_row(OP_QUERY, 0, 0, 'h4C8000, 1'b1, 44, 65536, 0);
    add_row(OP_QUERY, 0, 0, 'h4C8001);
    add_row(OP_QUERY, 0, 0, 'hEE8000, 1'b1, 3, 32768, 32768);
    add_row(OP_QUERY, 0, 0, 'hD47FFF);
    // equal neighbours give a zero divisor
    add_row(OP_LOAD, 1, 'hFC8000, 0);
    add_row(OP_QUERY, 0, 0, 'hFC8000, 1'b1, 0, 65536, 0);
    add_row(OP_QUERY, 0, 0, 'hFC7FFF);
    add_row(OP_LOAD, 1, 'hF88000, 0);
    add_row(OP_LOAD, 0, 'h000000, 0);
    add_row(OP_QUERY, 0, 0, 'h000001, 1'b1, 0, 65536, 0);
    add_row(OP_LOAD, 0, 'hFFFFFF, 0);
    add_row(OP_QUERY, 0, 0, 'hFFFFFF, 1'b1, 0, 65536, 0);
    add_row(OP_QUERY, 0, 0, 'hFE0000);
    // table not descending at the end entry
    add_row(OP_LOAD, 44, 'hFFFFFF, 0);
    add_row(OP_QUERY, 0, 0, 'h123456, 1'b1, 44, 65536, 0);
    add_row(OP_LOAD, 44, 'h4C8000, 0);
    add_row(OP_LOAD, 63, 'h000000, 0);
    add_row(OP_QUERY, 0, 0, 'h4C7FFF, 1'b1, 44, 65536, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r.op          = OP_LOAD;
      r.entry_index = IDX_W'(i);
      r.entry_value = VALUE_W'(((TABLE_DEPTH - 1 - i) << 18) + 'h8000);
      r.query_z     = '0;
      send_request(r, 1'b0, '0);
    end

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);

    phase_last[0] = IDX_W'(TABLE_DEPTH - 1);
    phase_last[1] = '0;
    phase_last[2] = IDX_W'(1);
    phase_last[3] = IDX_W'($urandom_range(2, 61));
    phase_last[4] = IDX_W'(TABLE_DEPTH - 2);
    phase_last[5] = IDX_W'($urandom_range(2, 61));
    phase_last[6] = LAST_RESET;
    foreach (phase_last[i]) begin
      write_last_index(phase_last[i]);
      run_phase(285);
    end

    start <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d loads and %0d queries over %0d last_index settings", n_loads,
             n_queries, n_settings);
    $display("checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && pending_segments.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/isl_pkg.sv
src/isl_table_ram.sv
src/isl_divider.sv
src/interp_segment_locator.sv
tb/testbench.sv
